// ===== rtl/core/trfq_pkg.sv =====
package trfq_pkg;

    localparam int SEQ_W  = 32;
    localparam int TIME_W = 48;
    localparam int TAG_W  = 32;
    localparam int CFG_W  = 5;
    localparam int OCC_W  = 5;

    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_SEEK = 2'd2
    } cmd_t;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] t;
        logic [TAG_W-1:0]  tag;
    } item_t;

    typedef struct packed {
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] t;
        logic [TAG_W-1:0]  tag;
    } frame_t;

    typedef struct packed {
        logic              ok;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] t;
        logic [TAG_W-1:0]  tag;
        logic [OCC_W-1:0]  occupancy;
    } result_t;

endpackage

// ===== rtl/core/trfq_if.sv =====
interface trfq_in_if;
    import trfq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               cmd;
    logic [SEQ_W-1:0]         in_sequence;
    logic signed [TIME_W-1:0] in_time;
    logic [TAG_W-1:0]         in_tag;

    modport source (output valid, output cmd, output in_sequence, output in_time,
                    output in_tag, input ready);
    modport sink (input valid, input cmd, input in_sequence, input in_time,
                  input in_tag, output ready);
endinterface

interface trfq_out_if;
    import trfq_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [SEQ_W-1:0]         out_sequence;
    logic signed [TIME_W-1:0] out_time;
    logic [TAG_W-1:0]         out_tag;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, output ok, output out_sequence, output out_time,
                    output out_tag, output occupancy, input ready);
    modport sink (input valid, input ok, input out_sequence, input out_time,
                  input out_tag, input occupancy, output ready);
endinterface

// ===== rtl/core/trfq_store.sv =====
module trfq_store
    import trfq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  frame_t                                wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output frame_t                                rdata
);

    frame_t mem [DEPTH];
    frame_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Write-first: a frame pushed into the slot that becomes the head is seen
    // by the next command.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/trfq_ctrl.sv =====
module trfq_ctrl
    import trfq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [CFG_W-1:0]                      cfg_data,
    input  logic                                  advance,
    input  item_t                                 item,
    input  frame_t                                head_frame,
    output logic                                  mem_we,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_waddr,
    output frame_t                                mem_wdata,
    output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] mem_raddr,
    output result_t                               result
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    logic [CFG_W-1:0]  capacity_reg;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [OCC_W-1:0]  count_reg, count_next;
    logic [SEQ_W-1:0]  last_seq_reg, last_seq_next;
    logic [TIME_W-1:0] floor_reg, floor_next;
    logic [CFG_W-1:0]  cap_eff;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    always_comb
    begin
        if (32'(capacity_reg) > 32'(DEPTH))
        begin
            cap_eff = CFG_W'(DEPTH);
        end
        else
        begin
            cap_eff = capacity_reg;
        end
    end

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        last_seq_next = last_seq_reg;
        floor_next    = floor_reg;
        mem_we        = 1'b0;
        result        = '0;
        if (advance)
        begin
            case (item.cmd)
                CMD_PUSH:
                begin
                    if ((count_reg < cap_eff) && (item.seq > last_seq_reg) &&
                        ($signed(item.t) >= $signed(floor_reg)))
                    begin
                        mem_we        = 1'b1;
                        tail_next     = next_index(tail_reg);
                        count_next    = count_reg + 1'b1;
                        last_seq_next = item.seq;
                        result.ok     = 1'b1;
                    end
                end
                CMD_POP:
                begin
                    if ((count_reg != '0) && ($signed(head_frame.t) <= $signed(item.t)))
                    begin
                        head_next  = next_index(head_reg);
                        count_next = count_reg - 1'b1;
                        result.ok  = 1'b1;
                        result.seq = head_frame.seq;
                        result.t   = head_frame.t;
                        result.tag = head_frame.tag;
                    end
                end
                CMD_SEEK:
                begin
                    head_next     = '0;
                    tail_next     = '0;
                    count_next    = '0;
                    last_seq_next = '0;
                    floor_next    = item.t[TIME_W-1] ? '0 : item.t;
                    result.ok     = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        result.occupancy = count_next;
    end

    assign mem_waddr = tail_reg;
    assign mem_wdata = '{seq: item.seq, t: item.t, tag: item.tag};
    // The store always reads the slot that will be the head, so the head
    // frame is ready for the following command.
    assign mem_raddr = head_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CFG_W'(16);
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            last_seq_reg <= '0;
            floor_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_data;
            end
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            last_seq_reg <= last_seq_next;
            floor_reg    <= floor_next;
        end
    end

endmodule

// ===== rtl/core/timed_release_frame_queue.sv =====
// Timed-release frame queue: a FIFO of frame descriptors gated by
// presentation time.
// Commands arrive on frame_in (cmd, in_sequence, in_time, in_tag); every
// command gives exactly one result on frame_out (ok, out_sequence, out_time,
// out_tag, occupancy). A transfer happens when valid and ready are both high.
// A command sits in an input register while the compares and pointer
// updates run, and its result is loaded into an output register.
// One command is taken every cycle while frame_out does not stall; the
// head frame is read from the store ahead of the command that uses it,
// so a pop that follows a pop or push needs no wait.
// When frame_out stalls, one command can still be taken into the input
// register; frame_in.ready drops only when both registers are full.
// The capacity register is written through cfg_wr_en and cfg_wr_data and
// should only be changed while no command is in flight.
// Reset (rst_n low) empties the queue, clears the last sequence and the
// seek floor, and sets capacity to 16. Store entries keep no reset value.
module timed_release_frame_queue
    import trfq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    trfq_in_if.sink          frame_in,
    trfq_out_if.source       frame_out
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic       in_valid_reg;
    item_t      item_reg;
    logic       res_valid_reg;
    result_t    res_reg;
    logic       advance;
    result_t    result;
    logic       mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;
    frame_t     mem_wdata;
    frame_t     head_frame;

    assign advance        = in_valid_reg && (!res_valid_reg || frame_out.ready);
    assign frame_in.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_in.valid && frame_in.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (frame_out.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_in.valid && frame_in.ready)
        begin
            item_reg.cmd <= frame_in.cmd;
            item_reg.seq <= frame_in.in_sequence;
            item_reg.t   <= frame_in.in_time;
            item_reg.tag <= frame_in.in_tag;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    trfq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_wr_en),
        .cfg_data   (cfg_wr_data),
        .advance    (advance),
        .item       (item_reg),
        .head_frame (head_frame),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .result     (result)
    );

    trfq_store #(.DEPTH(DEPTH)) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (head_frame)
    );

    assign frame_out.valid        = res_valid_reg;
    assign frame_out.ok           = res_reg.ok;
    assign frame_out.out_sequence = res_reg.seq;
    assign frame_out.out_time     = res_reg.t;
    assign frame_out.out_tag      = res_reg.tag;
    assign frame_out.occupancy    = res_reg.occupancy;

endmodule

// ===== rtl/core/trfq_checker.sv =====
module trfq_checker
    import trfq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              ok,
    input logic [SEQ_W-1:0]  out_sequence,
    input logic [TIME_W-1:0] out_time,
    input logic [TAG_W-1:0]  out_tag,
    input logic [OCC_W-1:0]  occupancy
);

    // A stalled result holds its fields until the transfer.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(ok) &&
        $stable(out_sequence) && $stable(out_time) && $stable(out_tag) &&
        $stable(occupancy)))
        else $error("stalled result changed");

    // The queue never reports more frames than it can store.
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(occupancy) <= 32'(DEPTH)))
        else $error("occupancy above depth");

    // A result without ok carries zero frame fields.
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> ((out_sequence == '0) && (out_time == '0) &&
        (out_tag == '0)))
        else $error("frame fields set without a returned frame");

    // With the output register empty the input side can always take a command.
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

endmodule

bind timed_release_frame_queue trfq_checker #(.DEPTH(DEPTH)) u_trfq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (frame_in.ready),
    .out_valid    (frame_out.valid),
    .out_ready    (frame_out.ready),
    .ok           (frame_out.ok),
    .out_sequence (frame_out.out_sequence),
    .out_time     (frame_out.out_time),
    .out_tag      (frame_out.out_tag),
    .occupancy    (frame_out.occupancy)
);
